// ===== src/htcpg_pkg.sv =====
// shared types and constants of the tripod gait oscillator block
`default_nettype none

package htcpg_pkg;

   // leg count and leg index width
   localparam int NUM_LEGS = 6;
   localparam int LEG_W    = 3;

   // oscillator state word, signed Q4.12
   localparam int STATE_W = 16;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // divide-by-five unit widths
   localparam int DIV_IN_W = 36;
   localparam int DIV_Q_W  = 34;

   // port widths of the top level
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 2 * NUM_LEGS * STATE_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   typedef logic [LEG_W-1:0] leg_type;
   typedef logic signed [STATE_W-1:0] osc_type;

   typedef struct packed {
      osc_type x;
      osc_type y;
   } osc_pair_type;

   // write side of the state memory
   typedef struct packed {
      logic         en;
      leg_type      addr;
      osc_pair_type data;
   } ram_wr_type;

   // +1.0 in Q4.12
   localparam osc_type OSC_ONE = 16'sd4096;

   // power-up state: group A legs at +1.0, group B legs at -1.0, y at zero
   function automatic osc_pair_type reset_pair(input leg_type leg);
      osc_pair_type pair;
      pair.x = leg[0] ? -OSC_ONE : OSC_ONE;
      pair.y = '0;
      return pair;
   endfunction

endpackage

`default_nettype wire

// ===== src/htcpg_state_ram.sv =====
// oscillator state memory, one x/y word per leg, registered read
`default_nettype none

module htcpg_state_ram (
   input  logic                   clock,
   input  logic                   reset,
   input  htcpg_pkg::ram_wr_type   wr,
   input  htcpg_pkg::leg_type      rd_addr,
   output htcpg_pkg::osc_pair_type rd_data
);
   import htcpg_pkg::*;

   osc_pair_type        state_mem [NUM_LEGS];
   osc_pair_type        rd_word_ff;
   leg_type             rd_addr_ff;
   logic                rd_valid_ff;
   logic [NUM_LEGS-1:0] valid_ff;

   // storage and read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         state_mem[wr.addr] <= wr.data;
      end
      rd_word_ff <= state_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // written flags, an entry not yet written reads as its power-up value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : reset_pair(rd_addr_ff);

endmodule

`default_nettype wire

// ===== src/htcpg_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none

module htcpg_mul (
   input  logic                                   clock,
   input  logic signed [htcpg_pkg::MUL_A_W-1:0]   a,
   input  logic signed [htcpg_pkg::MUL_B_W-1:0]   b,
   output logic signed [htcpg_pkg::MUL_P_W-1:0]   p
);
   import htcpg_pkg::*;

   logic signed [MUL_P_W-1:0] p_ff;

   // one product per cycle, ready the cycle after the operands
   always_ff @(posedge clock) begin
      p_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== src/htcpg_div5.sv =====
// serial divide by five, truncating toward zero, one byte per cycle
`default_nettype none

module htcpg_div5 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [htcpg_pkg::DIV_IN_W-1:0] dividend,
   output logic                                  done,
   output logic signed [htcpg_pkg::DIV_Q_W-1:0]  quot
);
   import htcpg_pkg::*;

   localparam int DIGIT_W = 8;
   localparam int DIGITS  = (DIV_IN_W + DIGIT_W - 1) / DIGIT_W;
   localparam int MAG_W   = DIGITS * DIGIT_W;
   localparam int PART_W  = DIGIT_W + 3;
   localparam int RECIP   = 3277;
   localparam int RECIP_W = 12;
   localparam int RECIP_S = 14;
   localparam int PROD_W  = PART_W + RECIP_W;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      neg_ff, neg_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic [2:0]                rem_ff, rem_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [MAG_W-1:0]          q_ff, q_in;
   logic signed [DIV_Q_W-1:0] quot_ff, quot_in;
   logic [DIV_IN_W-1:0]       abs_val;
   logic [PART_W-1:0]         part;
   logic [PROD_W-1:0]         recip_prod;
   logic [DIGIT_W-1:0]        qd;
   logic [PART_W-1:0]         back;

   always_comb begin
      // remainder and next byte, quotient digit by reciprocal multiply
      part       = {rem_ff, mag_ff[MAG_W-1 -: DIGIT_W]};
      recip_prod = PROD_W'(part) * PROD_W'(RECIP);
      qd         = recip_prod[RECIP_S +: DIGIT_W];
      back       = part - {1'b0, qd, 2'b00} - {3'b000, qd};
      abs_val    = dividend[DIV_IN_W-1] ? (~dividend + 1'b1) : dividend;

      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      q_in    = q_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = dividend[DIV_IN_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         mag_in  = {{(MAG_W-DIV_IN_W){1'b0}}, abs_val};
         q_in    = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 3'(DIGITS)) begin
            // apply the sign to the magnitude quotient
            quot_in = neg_ff ? (~q_ff[DIV_Q_W-1:0] + 1'b1) : q_ff[DIV_Q_W-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = back[2:0];
            mag_in = {mag_ff[MAG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            q_in   = {q_ff[MAG_W-DIGIT_W-1:0], qd};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      q_ff    <= q_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== src/hopf_tripod_cpg.sv =====
// Six coupled Hopf oscillators stepping a tripod gait, one Euler step per request word.
// Each request word carries a base angular rate (clamped below at 0.01 rad/s) and a turn
// bias; the block updates legs 0 to 5 in order, each leg seeing the x states already
// updated for earlier legs, and returns one response word with all twelve new states.
// The x/y states live in a six-entry state memory with one registered read port; each leg
// reads all six entries for its coupling sum, then runs its products through a single
// shared multiplier and a byte-serial divide by five. A new request word is taken only in
// the idle state, reached again once the response of the last word has been handed to the
// output register. A finished response waits in an output register while the next request
// word is accepted and processed. Register writes on the csr port are taken in any cycle
// and should only be made while the block is idle.
`default_nettype none

module hopf_tripod_cpg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // base_frequency [19:0], turn_bias [39:20]
   input  logic [htcpg_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // x_leg0..x_leg5 then y_leg0..y_leg5, 16 bits each from bit 0 up
   output logic [htcpg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [htcpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [htcpg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import htcpg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_GAIN    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CONVERGENCE_RATE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQUARED   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP        = CSR_IDX_W'(3);

   localparam logic signed [19:0] OMEGA_FLOOR = 20'sd41;
   localparam leg_type LAST_LEG  = leg_type'(NUM_LEGS - 1);
   localparam leg_type HALF_LEGS = leg_type'(NUM_LEGS / 2);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_SELF,
      ST_RD_SCAN,
      ST_RD_LAST,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_MUL_CPL,
      ST_MUL_WY,
      ST_MUL_CR,
      ST_MUL_WX,
      ST_MUL_GX,
      ST_MUL_GY,
      ST_SUM_DY,
      ST_ADD_CPL,
      ST_MUL_DXL,
      ST_MUL_DXH,
      ST_MUL_DYL,
      ST_MUL_DYH,
      ST_SAT_X,
      ST_RND_Y,
      ST_SAT_Y,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // round to nearest, ties away from zero, by 2^28
   function automatic logic signed [31:0] round28(input logic signed [59:0] v);
      logic signed [59:0] t;
      t = v + (v[59] ? 60'sd134217727 : 60'sd134217728);
      return t[59:28];
   endfunction

   // clamp to the 16-bit state range
   function automatic osc_type sat16(input logic signed [32:0] v);
      osc_type r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   state_type              state_ff, state_in;
   leg_type                leg_ff, leg_in;
   leg_type                scan_ff, scan_in;
   logic signed [19:0]     omega_ff, omega_in;
   logic signed [19:0]     bias_ff, bias_in;
   logic signed [20:0]     w_ff, w_in;
   osc_type                x_ff, x_in;
   osc_type                y_ff, y_in;
   logic signed [20:0]     s_ff, s_in;
   logic [31:0]            sq_ff, sq_in;
   logic signed [20:0]     err_ff, err_in;
   logic signed [25:0]     g_ff, g_in;
   logic signed [42:0]     wy_ff, wy_in;
   logic signed [42:0]     wx_ff, wx_in;
   logic signed [42:0]     dx_ff, dx_in;
   logic signed [42:0]     dy_ff, dy_in;
   logic signed [59:0]     acc_ff, acc_in;
   logic signed [31:0]     rx_ff, rx_in;
   logic signed [31:0]     ry_ff, ry_in;
   osc_type                nx_ff, nx_in;
   osc_type                ny_ff, ny_in;
   osc_type                new_x_ff [NUM_LEGS];
   osc_type                new_x_in [NUM_LEGS];
   osc_type                new_y_ff [NUM_LEGS];
   osc_type                new_y_in [NUM_LEGS];
   osc_type                rsp_x_ff [NUM_LEGS];
   osc_type                rsp_x_in [NUM_LEGS];
   osc_type                rsp_y_ff [NUM_LEGS];
   osc_type                rsp_y_in [NUM_LEGS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            gain_ff, conv_ff, rsq_ff, dt_ff;

   ram_wr_type                ram_wr;
   leg_type                   rd_addr;
   osc_pair_type              rd_data;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic                      div_start;
   logic                      div_done;
   logic signed [DIV_Q_W-1:0] div_quot;

   leg_type                peer;
   logic signed [16:0]     diff;
   logic signed [20:0]     cpl_term;
   logic signed [19:0]     req_base;
   logic [32:0]            sq_round;
   logic signed [MUL_P_W-1:0] g_round;

   htcpg_state_ram u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   htcpg_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   htcpg_div5 u_div5 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[DIV_IN_W-1:0]),
      .done     (div_done),
      .quot     (div_quot)
   );

   // coupling term of one peer leg: pull within the group, push across groups
   always_comb begin
      peer = (state_ff == ST_RD_LAST) ? LAST_LEG : (scan_ff - 1'b1);
      diff = $signed({rd_data.x[15], rd_data.x}) - $signed({x_ff[15], x_ff});
      if (peer == leg_ff) begin
         cpl_term = '0;
      end else if (peer[0] == leg_ff[0]) begin
         cpl_term = $signed({{4{diff[16]}}, diff});
      end else begin
         cpl_term = -$signed({{4{diff[16]}}, diff});
      end
   end

   // multiplier operand selection, product is consumed in the following state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_XX: begin
            mul_a = {{(MUL_A_W-STATE_W){x_ff[15]}}, x_ff};
            mul_b = {{(MUL_B_W-STATE_W){x_ff[15]}}, x_ff};
         end
         ST_MUL_YY: begin
            mul_a = {{(MUL_A_W-STATE_W){y_ff[15]}}, y_ff};
            mul_b = {{(MUL_B_W-STATE_W){y_ff[15]}}, y_ff};
         end
         ST_MUL_CPL: begin
            mul_a = {{(MUL_A_W-21){s_ff[20]}}, s_ff};
            mul_b = {2'b00, gain_ff};
         end
         ST_MUL_WY: begin
            mul_a = {{(MUL_A_W-21){w_ff[20]}}, w_ff};
            mul_b = {{(MUL_B_W-STATE_W){y_ff[15]}}, y_ff};
         end
         ST_MUL_CR: begin
            mul_a = {{(MUL_A_W-21){err_ff[20]}}, err_ff};
            mul_b = {2'b00, conv_ff};
         end
         ST_MUL_WX: begin
            mul_a = {{(MUL_A_W-21){w_ff[20]}}, w_ff};
            mul_b = {{(MUL_B_W-STATE_W){x_ff[15]}}, x_ff};
         end
         ST_MUL_GX: begin
            mul_a = {g_ff[25], g_ff};
            mul_b = {{(MUL_B_W-STATE_W){x_ff[15]}}, x_ff};
         end
         ST_MUL_GY: begin
            mul_a = {g_ff[25], g_ff};
            mul_b = {{(MUL_B_W-STATE_W){y_ff[15]}}, y_ff};
         end
         ST_MUL_DXL: begin
            mul_a = {5'b00000, dx_ff[21:0]};
            mul_b = {2'b00, dt_ff};
         end
         ST_MUL_DXH: begin
            mul_a = {{6{dx_ff[42]}}, dx_ff[42:22]};
            mul_b = {2'b00, dt_ff};
         end
         ST_MUL_DYL: begin
            mul_a = {5'b00000, dy_ff[21:0]};
            mul_b = {2'b00, dt_ff};
         end
         ST_MUL_DYH: begin
            mul_a = {{6{dy_ff[42]}}, dy_ff[42:22]};
            mul_b = {2'b00, dt_ff};
         end
         default: begin
         end
      endcase
   end

   // leg sequencer
   always_comb begin
      state_in     = state_ff;
      leg_in       = leg_ff;
      scan_in      = scan_ff;
      omega_in     = omega_ff;
      bias_in      = bias_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      s_in         = s_ff;
      sq_in        = sq_ff;
      err_in       = err_ff;
      g_in         = g_ff;
      wy_in        = wy_ff;
      wx_in        = wx_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rd_addr      = leg_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = leg_ff;
      ram_wr.data  = {nx_ff, ny_ff};
      div_start    = 1'b0;

      req_base = $signed(req_tdata[19:0]);
      sq_round = {1'b0, sq_ff} + 33'd2048;
      g_round  = prod + (prod[MUL_P_W-1] ? 45'sd2047 : 45'sd2048);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               omega_in = (req_base < OMEGA_FLOOR) ? OMEGA_FLOOR : req_base;
               bias_in  = $signed(req_tdata[39:20]);
               leg_in   = '0;
               state_in = ST_RD_SELF;
            end
         end
         ST_RD_SELF: begin
            rd_addr = leg_ff;
            if (leg_ff >= HALF_LEGS) begin
               w_in = $signed({omega_ff[19], omega_ff}) + $signed({bias_ff[19], bias_ff});
            end else begin
               w_in = $signed({omega_ff[19], omega_ff}) - $signed({bias_ff[19], bias_ff});
            end
            s_in     = '0;
            scan_in  = '0;
            state_in = ST_RD_SCAN;
         end
         ST_RD_SCAN: begin
            rd_addr = scan_ff;
            if (scan_ff == '0) begin
               x_in = rd_data.x;
               y_in = rd_data.y;
            end else begin
               s_in = s_ff + cpl_term;
            end
            if (scan_ff == LAST_LEG) begin
               state_in = ST_RD_LAST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_RD_LAST: begin
            s_in     = s_ff + cpl_term;
            state_in = ST_MUL_XX;
         end
         ST_MUL_XX: begin
            state_in = ST_MUL_YY;
         end
         ST_MUL_YY: begin
            sq_in    = prod[31:0];
            state_in = ST_MUL_CPL;
         end
         ST_MUL_CPL: begin
            sq_in    = sq_ff + prod[31:0];
            state_in = ST_MUL_WY;
         end
         ST_MUL_WY: begin
            // coupling product goes to the divider, squared radius error formed
            div_start = 1'b1;
            err_in    = $signed({5'b00000, rsq_ff}) - $signed(sq_round[32:12]);
            state_in  = ST_MUL_CR;
         end
         ST_MUL_CR: begin
            wy_in    = prod[42:0];
            state_in = ST_MUL_WX;
         end
         ST_MUL_WX: begin
            g_in     = g_round[37:12];
            state_in = ST_MUL_GX;
         end
         ST_MUL_GX: begin
            wx_in    = prod[42:0];
            state_in = ST_MUL_GY;
         end
         ST_MUL_GY: begin
            dx_in    = prod[42:0] - wy_ff;
            state_in = ST_SUM_DY;
         end
         ST_SUM_DY: begin
            dy_in    = prod[42:0] + wx_ff;
            state_in = ST_ADD_CPL;
         end
         ST_ADD_CPL: begin
            if (div_done) begin
               dx_in    = dx_ff + $signed({{(43-DIV_Q_W){div_quot[DIV_Q_W-1]}}, div_quot});
               state_in = ST_MUL_DXL;
            end
         end
         ST_MUL_DXL: begin
            state_in = ST_MUL_DXH;
         end
         ST_MUL_DXH: begin
            acc_in   = {{(60-MUL_P_W){prod[MUL_P_W-1]}}, prod};
            state_in = ST_MUL_DYL;
         end
         ST_MUL_DYL: begin
            acc_in   = acc_ff + $signed({prod[37:0], 22'd0});
            state_in = ST_MUL_DYH;
         end
         ST_MUL_DYH: begin
            rx_in    = round28(acc_ff);
            acc_in   = {{(60-MUL_P_W){prod[MUL_P_W-1]}}, prod};
            state_in = ST_SAT_X;
         end
         ST_SAT_X: begin
            acc_in   = acc_ff + $signed({prod[37:0], 22'd0});
            nx_in    = sat16($signed({{17{x_ff[15]}}, x_ff}) + $signed({rx_ff[31], rx_ff}));
            state_in = ST_RND_Y;
         end
         ST_RND_Y: begin
            ry_in    = round28(acc_ff);
            state_in = ST_SAT_Y;
         end
         ST_SAT_Y: begin
            ny_in    = sat16($signed({{17{y_ff[15]}}, y_ff}) + $signed({ry_ff[31], ry_ff}));
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ram_wr.en        = 1'b1;
            new_x_in[leg_ff] = nx_ff;
            new_y_in[leg_ff] = ny_ff;
            if (leg_ff == LAST_LEG) begin
               state_in = ST_FINISH;
            end else begin
               leg_in   = leg_ff + 1'b1;
               state_in = ST_RD_SELF;
            end
         end
         ST_FINISH: begin
            // hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_x_in     = new_x_ff;
               rsp_y_in     = new_y_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, working registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         leg_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         leg_ff       <= leg_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      omega_ff <= omega_in;
      bias_ff  <= bias_in;
      w_ff     <= w_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      s_ff     <= s_in;
      sq_ff    <= sq_in;
      err_ff   <= err_in;
      g_ff     <= g_in;
      wy_ff    <= wy_in;
      wx_ff    <= wx_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      acc_ff   <= acc_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      new_x_ff <= new_x_in;
      new_y_ff <= new_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 16'd2048;
         conv_ff <= 16'd4096;
         rsq_ff  <= 16'd4096;
         dt_ff   <= 16'd131;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COUPLING_GAIN:    gain_ff <= csr_data;
            CSR_CONVERGENCE_RATE: conv_ff <= csr_data;
            CSR_RADIUS_SQUARED:   rsq_ff  <= csr_data;
            CSR_TIME_STEP:        dt_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // response word packing
   always_comb begin
      for (int k = 0; k < NUM_LEGS; k++) begin
         rsp_tdata[k*STATE_W +: STATE_W]              = rsp_x_ff[k];
         rsp_tdata[(NUM_LEGS+k)*STATE_W +: STATE_W]   = rsp_y_ff[k];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire
